@@ hw/rtl/lsfb_pkg.sv @@
// lsfb_pkg: shared types, codes and constants of the led strip frame buffer
// no dependencies

package lsfb_pkg;

    localparam int LED_W  = 9;
    localparam int LVL_W  = 7;
    localparam int PIX_W  = 3 * LVL_W;
    localparam int LAT_W  = 4;
    localparam int BYTE_W = 8;

    localparam logic [LED_W-1:0]  STRAND_RESET = 9'd160;
    localparam logic [LAT_W-1:0]  LATCH_RESET  = 4'd5;
    localparam logic [LVL_W-1:0]  LEVEL_MAX    = 7'h7F;
    localparam logic [BYTE_W-1:0] DATA_MARK    = 8'h80;

    typedef enum logic [1:0] {
        KIND_FILL  = 2'd0,
        KIND_START = 2'd1,
        KIND_TAKE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_NO_FRAME  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_STRAND = 2'd0,
        REG_LATCH  = 2'd1
    } reg_index_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_BAD,
        OP_FILL,
        OP_START,
        OP_TAKE
    } op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_FILL,
        BK_READ
    } bk_state_t;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_PIX,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        op_t              op;
        logic [LED_W-1:0] first_idx;
        logic [LED_W-1:0] last_idx;
        logic [PIX_W-1:0] pixel;
    } cmd_t;

    typedef struct packed {
        logic [LED_W-1:0] eff_len;
        logic [LAT_W-1:0] eff_lat;
        logic             clear_req;
    } cfg_t;

    function automatic logic [LVL_W-1:0] sat_level(input logic signed [8:0] v);
        logic [LVL_W-1:0] r;
        if (v[8])
        begin
            r = '0;
        end
        else if (v[7])
        begin
            r = LEVEL_MAX;
        end
        else
        begin
            r = v[6:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/lsfb_ram.sv @@
// lsfb_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies

module lsfb_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/lsfb_front.sv @@
// lsfb_front: configuration registers and request classification
// depends on lsfb_pkg

module lsfb_front #(
    parameter int MAX_LEDS  = 256,
    parameter int MAX_LATCH = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [lsfb_pkg::LED_W-1:0]     cfg_wdata,
    input  logic [1:0]                     kind,
    input  logic [lsfb_pkg::LED_W-1:0]     first_led,
    input  logic [lsfb_pkg::LED_W-1:0]     last_led,
    input  logic signed [8:0]              red,
    input  logic signed [8:0]              green,
    input  logic signed [8:0]              blue,
    output lsfb_pkg::cmd_t                 cmd,
    output lsfb_pkg::cfg_t                 cfg
);

    logic [lsfb_pkg::LED_W-1:0] strand_reg;
    logic [lsfb_pkg::LAT_W-1:0] latch_reg;
    logic                       clear_req_reg;
    logic [lsfb_pkg::LED_W-1:0] eff_len;
    logic [lsfb_pkg::LAT_W-1:0] eff_lat;
    logic                       bad_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strand_reg    <= lsfb_pkg::STRAND_RESET;
            latch_reg     <= lsfb_pkg::LATCH_RESET;
            clear_req_reg <= 1'b0;
        end
        else
        begin
            clear_req_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    lsfb_pkg::REG_STRAND:
                    begin
                        if (cfg_wdata != strand_reg)
                        begin
                            strand_reg    <= cfg_wdata;
                            clear_req_reg <= 1'b1;
                        end
                    end
                    lsfb_pkg::REG_LATCH:
                    begin
                        if (cfg_wdata[lsfb_pkg::LAT_W-1:0] != latch_reg)
                        begin
                            latch_reg     <= cfg_wdata[lsfb_pkg::LAT_W-1:0];
                            clear_req_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (strand_reg == '0)
        begin
            eff_len = 9'd1;
        end
        else if (32'(strand_reg) > MAX_LEDS)
        begin
            eff_len = lsfb_pkg::LED_W'(MAX_LEDS);
        end
        else
        begin
            eff_len = strand_reg;
        end

        if (32'(latch_reg) > MAX_LATCH)
        begin
            eff_lat = lsfb_pkg::LAT_W'(MAX_LATCH);
        end
        else
        begin
            eff_lat = latch_reg;
        end
    end

    assign cfg.eff_len   = eff_len;
    assign cfg.eff_lat   = eff_lat;
    assign cfg.clear_req = clear_req_reg;

    assign bad_range = (first_led == '0) || (last_led < first_led) || (last_led > eff_len);

    always_comb
    begin
        cmd.first_idx = first_led - 9'd1;
        cmd.last_idx  = last_led - 9'd1;
        cmd.pixel     = {lsfb_pkg::sat_level(red), lsfb_pkg::sat_level(green),
                         lsfb_pkg::sat_level(blue)};
        unique case (kind)
            lsfb_pkg::KIND_FILL:  cmd.op = bad_range ? lsfb_pkg::OP_BAD : lsfb_pkg::OP_FILL;
            lsfb_pkg::KIND_START: cmd.op = lsfb_pkg::OP_START;
            lsfb_pkg::KIND_TAKE:  cmd.op = lsfb_pkg::OP_TAKE;
            default:              cmd.op = lsfb_pkg::OP_NOP;
        endcase
    end

endmodule

@@ hw/rtl/lsfb_cmd_fifo.sv @@
// lsfb_cmd_fifo: two-entry request queue between front and back
// depends on lsfb_pkg

module lsfb_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lsfb_pkg::cmd_t wr_cmd,
    output logic           q_full,
    input  logic           rd_en,
    output lsfb_pkg::cmd_t rd_cmd,
    output logic           q_empty
);

    lsfb_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({wr_en, rd_en})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign rd_cmd  = slot_reg[rd_ptr_reg];
    assign q_empty = (cnt_reg == 2'd0);
    assign q_full  = (cnt_reg == 2'd2);

endmodule

@@ hw/rtl/lsfb_back.sv @@
// lsfb_back: executes fills, frame start and byte takes on the pixel store
// depends on lsfb_pkg and lsfb_ram

module lsfb_back #(
    parameter int MAX_LEDS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lsfb_pkg::cfg_t              cfg,
    input  lsfb_pkg::cmd_t              q_cmd,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic                        out_pop,
    output logic                        out_valid,
    output logic [lsfb_pkg::BYTE_W-1:0] out_byte,
    output logic                        out_last,
    output logic [1:0]                  out_status,
    output logic                        clearing
);

    localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CMP_W = (IDX_W > lsfb_pkg::LED_W) ? IDX_W : lsfb_pkg::LED_W;

    lsfb_pkg::bk_state_t state_reg, state_next;
    lsfb_pkg::phase_t    phase_reg, phase_next;

    logic [IDX_W-1:0]          clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]          fill_idx_reg, fill_idx_next;
    logic [IDX_W-1:0]          fill_end_reg, fill_end_next;
    logic [lsfb_pkg::PIX_W-1:0] fill_px_reg, fill_px_next;
    logic                      active_reg, active_next;
    logic [lsfb_pkg::LAT_W-1:0] lat_cnt_reg, lat_cnt_next;
    logic [IDX_W-1:0]          led_reg, led_next;
    logic [1:0]                sub_reg, sub_next;
    logic [1:0]                rd_sub_reg, rd_sub_next;
    logic                      rd_last_reg, rd_last_next;

    logic                      out_valid_reg;
    logic [lsfb_pkg::BYTE_W-1:0] out_byte_reg;
    logic                      out_last_reg;
    logic [1:0]                out_status_reg;

    logic                      push_out;
    logic [lsfb_pkg::BYTE_W-1:0] push_byte;
    logic                      push_last;
    logic [1:0]                push_status;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [lsfb_pkg::PIX_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [lsfb_pkg::PIX_W-1:0] ram_rdata;

    logic                      slot_free;
    logic                      last_pix;
    logic [lsfb_pkg::LVL_W-1:0] level;

    lsfb_ram #(
        .WIDTH (lsfb_pkg::PIX_W),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (led_reg),
        .rd_data (ram_rdata)
    );

    assign slot_free = !out_valid_reg || out_pop;
    assign last_pix  = (CMP_W'(led_reg) == CMP_W'(cfg.eff_len - 9'd1)) && (sub_reg == 2'd2);

    always_comb
    begin
        case (rd_sub_reg)
            2'd0:    level = ram_rdata[lsfb_pkg::LVL_W-1:0];
            2'd1:    level = ram_rdata[3*lsfb_pkg::LVL_W-1:2*lsfb_pkg::LVL_W];
            default: level = ram_rdata[2*lsfb_pkg::LVL_W-1:lsfb_pkg::LVL_W];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsfb_pkg::BK_CLEAR;
            phase_reg     <= lsfb_pkg::PH_HEAD;
            clr_addr_reg  <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            clr_addr_reg <= clr_addr_next;
            active_reg   <= active_next;
            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_idx_reg <= fill_idx_next;
        fill_end_reg <= fill_end_next;
        fill_px_reg  <= fill_px_next;
        lat_cnt_reg  <= lat_cnt_next;
        led_reg      <= led_next;
        sub_reg      <= sub_next;
        rd_sub_reg   <= rd_sub_next;
        rd_last_reg  <= rd_last_next;
        if (push_out)
        begin
            out_byte_reg   <= push_byte;
            out_last_reg   <= push_last;
            out_status_reg <= push_status;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        clr_addr_next = clr_addr_reg;
        fill_idx_next = fill_idx_reg;
        fill_end_next = fill_end_reg;
        fill_px_next  = fill_px_reg;
        active_next   = active_reg;
        lat_cnt_next  = lat_cnt_reg;
        led_next      = led_reg;
        sub_next      = sub_reg;
        rd_sub_next   = rd_sub_reg;
        rd_last_next  = rd_last_reg;
        q_pop         = 1'b0;
        push_out      = 1'b0;
        push_byte     = '0;
        push_last     = 1'b0;
        push_status   = lsfb_pkg::ST_OK;
        ram_we        = 1'b0;
        ram_waddr     = clr_addr_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;

        if (cfg.clear_req)
        begin
            state_next    = lsfb_pkg::BK_CLEAR;
            clr_addr_next = '0;
            active_next   = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                lsfb_pkg::BK_CLEAR:
                begin
                    ram_we      = 1'b1;
                    active_next = 1'b0;
                    if (clr_addr_reg == IDX_W'(MAX_LEDS - 1))
                    begin
                        clr_addr_next = '0;
                        state_next    = lsfb_pkg::BK_IDLE;
                    end
                    else
                    begin
                        clr_addr_next = clr_addr_reg + 1'b1;
                    end
                end
                lsfb_pkg::BK_FILL:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = fill_idx_reg;
                    ram_wdata = fill_px_reg;
                    if (fill_idx_reg == fill_end_reg)
                    begin
                        push_out   = 1'b1;
                        state_next = lsfb_pkg::BK_IDLE;
                    end
                    else
                    begin
                        fill_idx_next = fill_idx_reg + 1'b1;
                    end
                end
                lsfb_pkg::BK_READ:
                begin
                    push_out   = 1'b1;
                    push_byte  = lsfb_pkg::DATA_MARK | {1'b0, level};
                    push_last  = rd_last_reg;
                    state_next = lsfb_pkg::BK_IDLE;
                end
                lsfb_pkg::BK_IDLE:
                begin
                    if (!q_empty && slot_free)
                    begin
                        q_pop = 1'b1;
                        unique case (q_cmd.op)
                            lsfb_pkg::OP_BAD:
                            begin
                                push_out    = 1'b1;
                                push_status = lsfb_pkg::ST_BAD_RANGE;
                            end
                            lsfb_pkg::OP_FILL:
                            begin
                                fill_idx_next = IDX_W'(q_cmd.first_idx);
                                fill_end_next = IDX_W'(q_cmd.last_idx);
                                fill_px_next  = q_cmd.pixel;
                                state_next    = lsfb_pkg::BK_FILL;
                            end
                            lsfb_pkg::OP_START:
                            begin
                                push_out     = 1'b1;
                                active_next  = 1'b1;
                                lat_cnt_next = '0;
                                led_next     = '0;
                                sub_next     = 2'd0;
                                phase_next   = (cfg.eff_lat == '0) ? lsfb_pkg::PH_PIX
                                                                   : lsfb_pkg::PH_HEAD;
                            end
                            lsfb_pkg::OP_TAKE:
                            begin
                                if (!active_reg)
                                begin
                                    push_out    = 1'b1;
                                    push_status = lsfb_pkg::ST_NO_FRAME;
                                end
                                else
                                begin
                                    unique case (phase_reg)
                                        lsfb_pkg::PH_HEAD:
                                        begin
                                            push_out = 1'b1;
                                            if (5'(lat_cnt_reg) + 5'd1 == 5'(cfg.eff_lat))
                                            begin
                                                phase_next = lsfb_pkg::PH_PIX;
                                                led_next   = '0;
                                                sub_next   = 2'd0;
                                            end
                                            else
                                            begin
                                                lat_cnt_next = lat_cnt_reg + 1'b1;
                                            end
                                        end
                                        lsfb_pkg::PH_PIX:
                                        begin
                                            ram_re       = 1'b1;
                                            rd_sub_next  = sub_reg;
                                            rd_last_next = last_pix && (cfg.eff_lat == '0);
                                            state_next   = lsfb_pkg::BK_READ;
                                            if (sub_reg == 2'd2)
                                            begin
                                                sub_next = 2'd0;
                                                led_next = led_reg + 1'b1;
                                            end
                                            else
                                            begin
                                                sub_next = sub_reg + 2'd1;
                                            end
                                            if (last_pix)
                                            begin
                                                if (cfg.eff_lat == '0)
                                                begin
                                                    active_next = 1'b0;
                                                end
                                                else
                                                begin
                                                    phase_next   = lsfb_pkg::PH_TAIL;
                                                    lat_cnt_next = '0;
                                                end
                                            end
                                        end
                                        default:
                                        begin
                                            push_out = 1'b1;
                                            if (lat_cnt_reg == cfg.eff_lat - 4'd1)
                                            begin
                                                push_last   = 1'b1;
                                                active_next = 1'b0;
                                            end
                                            else
                                            begin
                                                lat_cnt_next = lat_cnt_reg + 1'b1;
                                            end
                                        end
                                    endcase
                                end
                            end
                            default:
                            begin
                                push_out = 1'b1;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_next = lsfb_pkg::BK_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;
    assign clearing   = (state_reg == lsfb_pkg::BK_CLEAR);

endmodule

@@ hw/rtl/led_strip_frame_buffer.sv @@
// led_strip_frame_buffer: top level, front classifier, request queue and back executor
// depends on lsfb_pkg, lsfb_front, lsfb_cmd_fifo, lsfb_back, lsfb_ram
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  request  | push / full      | kind, first_led, last_led, red, green, blue
//  result   | empty / pop      | frame_byte, last_byte, status
//  config   | cfg_we           | cfg_index, cfg_wdata
//
// a take of a pixel byte passes the registered store read in the back before its result is pushed;
// start, latch bytes, rejected fills and refusals are answered from idle, a fill writes its leds in turn
// after reset and after a register write that changes its value, a clearing pass
// writes all MAX_LEDS entries of the pixel store to zero with full held high
// a two-entry queue lets the front accept requests while a result waits on pop

module led_strip_frame_buffer #(
    parameter int MAX_LEDS  = 256,
    parameter int MAX_LATCH = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        kind,
    input  logic [8:0]        first_led,
    input  logic [8:0]        last_led,
    input  logic signed [8:0] red,
    input  logic signed [8:0] green,
    input  logic signed [8:0] blue,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        frame_byte,
    output logic              last_byte,
    output logic [1:0]        status,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_wdata
);

    lsfb_pkg::cmd_t front_cmd;
    lsfb_pkg::cmd_t q_cmd;
    lsfb_pkg::cfg_t cfg;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           push_fire;
    logic           pop_fire;
    logic           out_valid;
    logic           clearing;

    assign full      = q_full || clearing || cfg.clear_req;
    assign push_fire = push && !full;
    assign empty     = !out_valid;
    assign pop_fire  = pop && out_valid;

    lsfb_front #(
        .MAX_LEDS  (MAX_LEDS),
        .MAX_LATCH (MAX_LATCH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .kind      (kind),
        .first_led (first_led),
        .last_led  (last_led),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .cmd       (front_cmd),
        .cfg       (cfg)
    );

    lsfb_cmd_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push_fire),
        .wr_cmd  (front_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (q_cmd),
        .q_empty (q_empty)
    );

    lsfb_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_cmd      (q_cmd),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_pop    (pop_fire),
        .out_valid  (out_valid),
        .out_byte   (frame_byte),
        .out_last   (last_byte),
        .out_status (status),
        .clearing   (clearing)
    );

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("request port open during clearing pass");

    a_last_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_byte) |-> (status == lsfb_pkg::ST_OK))
        else $error("last byte flagged on a failed result");

    a_error_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != lsfb_pkg::ST_OK) |-> (frame_byte == '0))
        else $error("nonzero frame byte on a failed result");

    a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire |=> !q_empty)
        else $error("accepted request missing from queue");

endmodule
